// ===== rtl/core/fpt_pkg.sv =====
// Shared types and constants for the FIFO page translation unit.
// Holds the beat structs, the controller/datapath link structs and page geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpt_pkg;

	// Page geometry: both sizes are powers of two, so the page number and
	// the offset are plain bit fields of the virtual address.
	localparam int PAGE_WORDS         = 256;
	localparam int VIRTUAL_PAGES      = 256;
	localparam int OFFSET_BITS        = $clog2(PAGE_WORDS);
	localparam int PAGE_BITS          = $clog2(VIRTUAL_PAGES);
	localparam int FRAME_COUNT_DEFAULT = 16;

	localparam int VADDR_BITS = 16;
	localparam int PADDR_BITS = 12;
	localparam int FIDX_BITS  = 4;
	localparam int CNT_BITS   = 32;

	localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

	// Request modes
	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [VADDR_BITS-1:0] virtual_address;
	} request_t;

	typedef struct packed {
		logic                  hit;
		logic [PADDR_BITS-1:0] physical_address;
		logic [FIDX_BITS-1:0]  frame_index;
		logic [PAGE_BITS-1:0]  evicted_page;
		logic [PAGE_BITS-1:0]  loaded_page;
		logic [CNT_BITS-1:0]   reference_count;
		logic [CNT_BITS-1:0]   fault_count;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;  // take the input beat and register the tag compare
		logic commit;   // resolve, update table and counts, load the result
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free; // result register can take a new beat this cycle
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fpt_ctrl.sv =====
// Controller state machine for the FIFO page translation unit.
// Sequences capture and commit of one request; depends on fpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fpt_pkg::dp_status_t status,
	output fpt_pkg::ctrl_cmd_t     cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_COMMIT = 1'b1;

	logic state_q;
	logic state_next;

	always_comb begin
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		state_next  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// hold until the result register can take the beat
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpt_datapath.sv =====
// Datapath of the FIFO page translation unit: frame owner table, tag compare,
// victim pointer, saturating counts and the result register. Depends on fpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpt_datapath #(
	parameter int FRAME_COUNT = fpt_pkg::FRAME_COUNT_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpt_pkg::request_t  in_data,
	input  wire fpt_pkg::ctrl_cmd_t cmd,
	output fpt_pkg::dp_status_t     status,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output fpt_pkg::result_t        out_data
);

	localparam int FW    = $clog2(FRAME_COUNT);
	localparam int PB    = fpt_pkg::PAGE_BITS;
	localparam int OB    = fpt_pkg::OFFSET_BITS;
	localparam int CB    = fpt_pkg::CNT_BITS;
	localparam logic [FW-1:0] LAST_FRAME = FW'(FRAME_COUNT - 1);

	logic [PB-1:0]          owner_q [FRAME_COUNT];
	logic [FW-1:0]          victim_q;
	logic [CB-1:0]          access_q;
	logic [CB-1:0]          fault_q;
	logic                   out_valid_q;
	fpt_pkg::result_t       out_q;

	logic                   mode_s1;
	logic [PB-1:0]          page_s1;
	logic [OB-1:0]          offset_s1;
	logic [FRAME_COUNT-1:0] match_s1;

	logic [PB-1:0]          in_page;
	logic                   found;
	logic [FW-1:0]          hit_frame;
	logic [FW-1:0]          frame;
	logic [31:0]            phys_wide;
	logic [31:0]            frame_wide;
	logic [CB-1:0]          access_inc;
	logic [CB-1:0]          fault_inc;
	fpt_pkg::result_t       result;

	assign in_page = in_data.virtual_address[OB +: PB];

	// lowest matching frame wins
	always_comb begin
		found     = 1'b0;
		hit_frame = '0;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				found     = 1'b1;
				hit_frame = FW'(i);
			end
		end
	end

	assign frame      = found ? hit_frame : victim_q;
	assign phys_wide  = 32'({frame, offset_s1});
	assign frame_wide = 32'(frame);
	assign access_inc = (access_q == fpt_pkg::COUNT_MAX) ? access_q : access_q + 1'b1;
	assign fault_inc  = (fault_q == fpt_pkg::COUNT_MAX) ? fault_q : fault_q + 1'b1;

	always_comb begin
		result = '0;
		if (mode_s1 == fpt_pkg::MODE_ACCESS) begin
			result.hit              = found;
			result.physical_address = phys_wide[fpt_pkg::PADDR_BITS-1:0];
			result.frame_index      = frame_wide[fpt_pkg::FIDX_BITS-1:0];
			result.evicted_page     = found ? '0 : owner_q[victim_q];
			result.loaded_page      = found ? '0 : page_s1;
			result.reference_count  = access_inc;
			result.fault_count      = found ? fault_q : fault_inc;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;

	// capture stage: register the request and compare it against every frame
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1   <= in_data.mode;
			page_s1   <= in_page;
			offset_s1 <= in_data.virtual_address[OB-1:0];
			for (int i = 0; i < FRAME_COUNT; i++) begin
				match_s1[i] <= (owner_q[i] == in_page);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_COUNT; i++) begin
				owner_q[i] <= PB'(i);
			end
			victim_q    <= '0;
			access_q    <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (mode_s1 == fpt_pkg::MODE_CLEAR) begin
					access_q <= '0;
					fault_q  <= '0;
				end else begin
					access_q <= access_inc;
					if (!found) begin
						fault_q           <= fault_inc;
						owner_q[victim_q] <= page_s1;
						victim_q          <= (victim_q == LAST_FRAME) ? '0 : victim_q + 1'b1;
					end
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/fifo_page_translation_unit.sv =====
// FIFO page translation unit, top level.
// Joins the controller (fpt_ctrl) and the datapath (fpt_datapath); uses fpt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one request beat. mode 0
//   translates virtual_address, mode 1 clears the reference and fault counts.
//   Output channel (out_valid / out_stall / out_data): one result beat per
//   request, in request order.
//   A request is registered and compared against every frame when it is
//   accepted, then committed into the result register once that register
//   can take it. in_stall stays high until the commit, so a new request is
//   accepted only after the previous one has committed.
//   While a result waits on out_stall, the next request is still accepted and
//   compared; its commit holds until the result register is taken.
//   Reset (arst_n low) empties the result register, sets frame i to hold
//   page i, the victim pointer to frame 0 and both counts to 0; no clearing
//   pass follows, the first request is taken right after reset.
//   On a fault the frame under the victim pointer is reused round-robin.
`timescale 1ns / 1ps
`default_nettype none

module fifo_page_translation_unit #(
	parameter int FRAME_COUNT = fpt_pkg::FRAME_COUNT_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fpt_pkg::request_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fpt_pkg::result_t       out_data
);

	fpt_pkg::ctrl_cmd_t  cmd;
	fpt_pkg::dp_status_t status;

	// sequence each request: capture with compare, then commit
	fpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// table, victim pointer, counts and result register
	fpt_datapath #(
		.FRAME_COUNT (FRAME_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
